FILE: design/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, sizes and helpers for the four-influence skinning pipeline.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int MAX_JOINTS      = 64;
  localparam int WORDS_PER_JOINT = 12;
  localparam int NUM_INF         = 4;
  localparam int PAL_DEPTH       = MAX_JOINTS * WORDS_PER_JOINT;
  localparam int JOINT_AW        = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JID_W           = 6;
  localparam int WGT_W           = 16;
  localparam int ADDR_W          = 10;
  localparam int ELEM_W          = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SKIN  = 1'b1;

  typedef logic signed [31:0]         q16_t;
  typedef q16_t [WORDS_PER_JOINT-1:0] mat_t;
  typedef q16_t [2:0]                 vec3_t;
  typedef logic signed [47:0]         bprod_t;
  typedef logic signed [63:0]         xprod_t;
  typedef logic signed [66:0]         wide_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic q16_t sat_q16(input wide_t v);
    if (v > wide_t'(64'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -wide_t'(64'sh8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: design/lbs_if.sv
// ----------------------------------------------------------------------------
// lbs_in_if / lbs_out_if
// Valid/ready channels for vertex/palette words and skinned results.
// ----------------------------------------------------------------------------
interface lbs_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  logic [9:0]          pal_addr;
  logic signed [31:0]  pal_value;
  logic [23:0]         joint_ids;
  logic [63:0]         blend_weights;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic signed [31:0]  pos_z;
  logic signed [31:0]  nrm_x;
  logic signed [31:0]  nrm_y;
  logic signed [31:0]  nrm_z;

  modport source (output valid, func, pal_addr, pal_value, joint_ids, blend_weights,
                  pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, input ready);
  modport sink   (input valid, func, pal_addr, pal_value, joint_ids, blend_weights,
                  pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, output ready);
endinterface

interface lbs_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  out_pos_x;
  logic signed [31:0]  out_pos_y;
  logic signed [31:0]  out_pos_z;
  logic signed [31:0]  out_nrm_x;
  logic signed [31:0]  out_nrm_y;
  logic signed [31:0]  out_nrm_z;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                  out_nrm_x, out_nrm_y, out_nrm_z, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z,
                  out_nrm_x, out_nrm_y, out_nrm_z, output ready);
endinterface

FILE: design/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lbs_blend.sv
// ----------------------------------------------------------------------------
// lbs_blend
// Weights four joint matrices and sums them into one rounded Q16.16 matrix.
// ----------------------------------------------------------------------------
module lbs_blend import lbs_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  mat_t                     mats [NUM_INF],
  input  logic [NUM_INF*WGT_W-1:0] weights,
  input  logic [NUM_INF-1:0]       jvalid,
  output mat_t                     blend_r
);

  bprod_t prod_r [NUM_INF][WORDS_PER_JOINT];
  mat_t   blend_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_INF; k++) begin
        for (int e = 0; e < WORDS_PER_JOINT; e++) begin
          // out-of-range joint contributes a zero matrix
          prod_r[k][e] <= jvalid[k] ?
            bprod_t'(mats[k][e] * $signed({1'b0, weights[k*WGT_W +: WGT_W]})) : '0;
        end
      end
      blend_r <= blend_nxt;
    end
  end

  always_comb begin
    wide_t acc;
    for (int e = 0; e < WORDS_PER_JOINT; e++) begin
      acc = wide_t'(16384);
      for (int k = 0; k < NUM_INF; k++) begin
        acc = acc + wide_t'(prod_r[k][e]);
      end
      blend_nxt[e] = sat_q16(acc >>> 15);
    end
  end

endmodule

FILE: design/lbs_xform.sv
// ----------------------------------------------------------------------------
// lbs_xform
// Applies the blended matrix to the position (point) and normal (vector).
// ----------------------------------------------------------------------------
module lbs_xform import lbs_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  mat_t  blend,
  input  vec3_t pos,
  input  vec3_t nrm,
  output vec3_t pos_r,
  output vec3_t nrm_r
);

  xprod_t pp_r [3][3];
  xprod_t np_r [3][3];
  q16_t   tr_r [3];
  vec3_t  pos_nxt;
  vec3_t  nrm_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp_r[r][c] <= blend[r*4 + c] * pos[c];
          np_r[r][c] <= blend[r*4 + c] * nrm[c];
        end
        tr_r[r] <= blend[r*4 + 3];
      end
      pos_r <= pos_nxt;
      nrm_r <= nrm_nxt;
    end
  end

  always_comb begin
    wide_t ps;
    wide_t ns;
    for (int r = 0; r < 3; r++) begin
      // translation lifted to 32 fraction bits, then round-half-up at bit 15
      ps = (wide_t'(tr_r[r]) <<< 16) + wide_t'(32768);
      ns = wide_t'(32768);
      for (int c = 0; c < 3; c++) begin
        ps = ps + wide_t'(pp_r[r][c]);
        ns = ns + wide_t'(np_r[r][c]);
      end
      pos_nxt[r] = sat_q16(ps >>> 16);
      nrm_nxt[r] = sat_q16(ns >>> 16);
    end
  end

endmodule

FILE: design/linear_blend_skinning_top.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_top
// Four-influence linear blend skinning with a replicated joint palette.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  in_ch    in   palette write (func=0) or vertex to skin (func=1)
//  out_ch   out  skinned position and normal, Q16.16
//
//  One word per cycle while the output is not held. A vertex passes five
//  register stages after acceptance: palette read, weight multiply, blend sum,
//  transform multiply and transform sum. The palette is held as 4 copies x 12
//  element banks so all 48 matrix words are read together.
//  Palette writes land at acceptance and yield no result.
//  All stages stall together when the output word is held; in_ch.ready is
//  low only while an output word waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module linear_blend_skinning_top import lbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  lbs_in_if.sink   in_ch,
  lbs_out_if.source out_ch
);

  logic        adv;
  logic        in_acc;
  logic [4:0]  vld_r;
  logic        wr_en;
  logic [19:0] div_prod;
  logic [6:0]  wr_joint;
  logic [ELEM_W-1:0] wr_elem;

  mat_t  mats [NUM_INF];
  logic [NUM_INF*WGT_W-1:0] wgt_r;
  logic [NUM_INF-1:0]       jvld_r;
  logic [NUM_INF-1:0]       jvld_nxt;
  vec3_t pos_r [3];
  vec3_t nrm_r [3];
  mat_t  blend;
  vec3_t opos;
  vec3_t onrm;

  assign adv          = !vld_r[4] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign in_acc       = in_ch.valid && adv;

  // joint = addr / 12 via reciprocal 683/8192, exact for 10-bit addresses
  assign div_prod = 20'(in_ch.pal_addr) * 20'd683;
  assign wr_joint = div_prod[19:13];
  assign wr_elem  = ELEM_W'(in_ch.pal_addr - 10'(wr_joint) * 10'd12);
  assign wr_en    = in_acc && (in_ch.func == FUNC_WRITE) &&
                    ({2'b0, in_ch.pal_addr} < 12'(PAL_DEPTH));

  for (genvar k = 0; k < NUM_INF; k++) begin : g_copy
    for (genvar e = 0; e < WORDS_PER_JOINT; e++) begin : g_bank
      lbs_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_ram (
        .clk   (clk),
        .we    (wr_en && (wr_elem == ELEM_W'(e))),
        .waddr (JOINT_AW'(wr_joint)),
        .wdata (in_ch.pal_value),
        .re    (adv),
        .raddr (JOINT_AW'(in_ch.joint_ids[k*JID_W +: JID_W])),
        .rdata (mats[k][e])
      );
    end
    assign jvld_nxt[k] = 32'(in_ch.joint_ids[k*JID_W +: JID_W]) < 32'(MAX_JOINTS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_acc && (in_ch.func == FUNC_SKIN)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wgt_r    <= in_ch.blend_weights;
      jvld_r   <= jvld_nxt;
      pos_r[0] <= '{in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
      nrm_r[0] <= '{in_ch.nrm_z, in_ch.nrm_y, in_ch.nrm_x};
      pos_r[1] <= pos_r[0];
      nrm_r[1] <= nrm_r[0];
      pos_r[2] <= pos_r[1];
      nrm_r[2] <= nrm_r[1];
    end
  end

  lbs_blend u_blend (
    .clk     (clk),
    .en      (adv),
    .mats    (mats),
    .weights (wgt_r),
    .jvalid  (jvld_r),
    .blend_r (blend)
  );

  lbs_xform u_xform (
    .clk   (clk),
    .en    (adv),
    .blend (blend),
    .pos   (pos_r[2]),
    .nrm   (nrm_r[2]),
    .pos_r (opos),
    .nrm_r (onrm)
  );

  assign out_ch.valid     = vld_r[4];
  assign out_ch.out_pos_x = opos[0];
  assign out_ch.out_pos_y = opos[1];
  assign out_ch.out_pos_z = opos[2];
  assign out_ch.out_nrm_x = onrm[0];
  assign out_ch.out_nrm_y = onrm[1];
  assign out_ch.out_nrm_z = onrm[2];

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.func == FUNC_WRITE) |=> !vld_r[0])
    else $error("palette write entered the result pipe");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_skin_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && adv |=> out_ch.valid)
    else $error("vertex lost before output");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Skinning pipeline check: palette uploads and vertex words are streamed in
// bursts while the result side stalls; every skinned word is compared with a
// hand-written result or a local fixed-point predictor of blend and transform.
// ----------------------------------------------------------------------------
module tb_top;
  import lbs_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 650;

  typedef struct {
    logic        func;
    logic [9:0]  pal_addr;
    q16_t        pal_value;
    logic [23:0] joint_ids;
    logic [63:0] blend_weights;
    q16_t        pos [3];
    q16_t        nrm [3];
  } word_t;

  typedef q16_t [5:0] skin_res_t;

  logic clk;
  logic rst_n;

  lbs_in_if  in_ch();
  lbs_out_if out_ch();

  linear_blend_skinning_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  q16_t      palette_mirror [PAL_DEPTH];
  skin_res_t skinned_q [$];
  int        n_errors;
  int        n_writes;
  int        n_skins;
  int        n_checked;
  int        n_sat;
  int        burst_left;
  bit        joint_loaded [MAX_JOINTS];
  int        loaded_joints [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---- prediction --------------------------------------------------------
  function automatic q16_t clamp32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -72'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic skin_res_t skin_vertex(input word_t w);
    logic signed [71:0] acc [WORDS_PER_JOINT];
    q16_t               m [WORDS_PER_JOINT];
    logic signed [71:0] sp, sn;
    skin_res_t          r;
    int                 j;
    for (int e = 0; e < WORDS_PER_JOINT; e++) acc[e] = 0;
    for (int k = 0; k < NUM_INF; k++) begin
      j = int'(w.joint_ids[JID_W*k +: JID_W]);
      if (j < MAX_JOINTS) begin
        for (int e = 0; e < WORDS_PER_JOINT; e++)
          acc[e] += 72'(palette_mirror[j*WORDS_PER_JOINT + e]) *
                    $signed({56'd0, w.blend_weights[WGT_W*k +: WGT_W]});
      end
    end
    for (int e = 0; e < WORDS_PER_JOINT; e++) m[e] = clamp32((acc[e] + 16384) >>> 15);
    for (int row = 0; row < 3; row++) begin
      sp = 72'(m[row*4]) * 72'(w.pos[0]) + 72'(m[row*4+1]) * 72'(w.pos[1]) +
           72'(m[row*4+2]) * 72'(w.pos[2]) + (72'(m[row*4+3]) <<< 16);
      sn = 72'(m[row*4]) * 72'(w.nrm[0]) + 72'(m[row*4+1]) * 72'(w.nrm[1]) +
           72'(m[row*4+2]) * 72'(w.nrm[2]);
      r[row]   = clamp32((sp + 32768) >>> 16);
      r[3+row] = clamp32((sn + 32768) >>> 16);
    end
    return r;
  endfunction

  // ---- stimulus helpers ----------------------------------------------------
  function automatic word_t pal_write(input int addr, input q16_t val);
    word_t w;
    w.func = FUNC_WRITE;
    w.pal_addr = 10'(addr);
    w.pal_value = val;
    w.joint_ids = 24'($urandom);
    w.blend_weights = {$urandom, $urandom};
    for (int i = 0; i < 3; i++) begin
      w.pos[i] = $urandom;
      w.nrm[i] = $urandom;
    end
    return w;
  endfunction

  function automatic word_t vtx(input logic [23:0] ids, input logic [63:0] wts,
                                input q16_t px, input q16_t py, input q16_t pz,
                                input q16_t nx, input q16_t ny, input q16_t nz);
    word_t w;
    w.func = FUNC_SKIN;
    w.pal_addr = 10'($urandom);
    w.pal_value = $urandom;
    w.joint_ids = ids;
    w.blend_weights = wts;
    w.pos[0] = px; w.pos[1] = py; w.pos[2] = pz;
    w.nrm[0] = nx; w.nrm[1] = ny; w.nrm[2] = nz;
    return w;
  endfunction

  function automatic q16_t rnd_elem();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
      6, 7:             return $urandom;
      8:                return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default:          return $urandom_range(0, 1) ? 32'sh0001_0000 : 32'sh0;
    endcase
  endfunction

  function automatic q16_t rnd_coord();
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 1 << 27)) - (1 << 26);
      5, 6:          return $urandom;
      default:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  function automatic logic [63:0] rnd_weights();
    int a, b, c;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        // partition of unity, as an exporter would produce
        a = $urandom_range(0, 32768);
        b = $urandom_range(0, 32768 - a);
        c = $urandom_range(0, 32768 - a - b);
        return {16'(32768 - a - b - c), 16'(c), 16'(b), 16'(a)};
      end
      3:       return {$urandom, $urandom};
      4:       return 64'h0000_0000_0000_8000 << (16 * $urandom_range(0, 3));
      default: return {16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom)};
    endcase
  endfunction

  // ---- sender ----------------------------------------------------------------
  task automatic send(input word_t w, input bit hand, input skin_res_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.func          <= w.func;
    in_ch.pal_addr      <= w.pal_addr;
    in_ch.pal_value     <= w.pal_value;
    in_ch.joint_ids     <= w.joint_ids;
    in_ch.blend_weights <= w.blend_weights;
    in_ch.pos_x <= w.pos[0]; in_ch.pos_y <= w.pos[1]; in_ch.pos_z <= w.pos[2];
    in_ch.nrm_x <= w.nrm[0]; in_ch.nrm_y <= w.nrm[1]; in_ch.nrm_z <= w.nrm[2];
    do @(posedge clk); while (!in_ch.ready);
    if (w.func == FUNC_WRITE) begin
      n_writes++;
      if (w.pal_addr < PAL_DEPTH) palette_mirror[w.pal_addr] = w.pal_value;
    end else begin
      n_skins++;
      skinned_q.push_back(hand ? want : skin_vertex(w));
    end
  endtask

  task automatic upload_joint(input int j);
    for (int e = 0; e < WORDS_PER_JOINT; e++)
      send(pal_write(j*WORDS_PER_JOINT + e, rnd_elem()), 1'b0, '0);
    if (!joint_loaded[j]) begin
      joint_loaded[j] = 1'b1;
      loaded_joints.push_back(j);
    end
  endtask

  // ---- receiver and checker ---------------------------------------------------
  task automatic report(input string what, input q16_t got, input q16_t want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  int rx_mode;
  int rx_left;

  always @(posedge clk) begin
    skin_res_t want;
    skin_res_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode = 0;
      rx_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_nrm_z, out_ch.out_nrm_y, out_ch.out_nrm_x,
               out_ch.out_pos_z, out_ch.out_pos_y, out_ch.out_pos_x};
        if (skinned_q.size() == 0) begin
          report("unexpected word", got[0], '0);
        end else begin
          want = skinned_q.pop_front();
          if (got[0] != want[0]) report("out_pos_x", got[0], want[0]);
          if (got[1] != want[1]) report("out_pos_y", got[1], want[1]);
          if (got[2] != want[2]) report("out_pos_z", got[2], want[2]);
          if (got[3] != want[3]) report("out_nrm_x", got[3], want[3]);
          if (got[4] != want[4]) report("out_nrm_y", got[4], want[4]);
          if (got[5] != want[5]) report("out_nrm_z", got[5], want[5]);
          for (int i = 0; i < 6; i++)
            if (got[i] == 32'sh7FFF_FFFF || got[i] == 32'sh8000_0000) n_sat++;
        end
        n_checked++;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 1);
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (rx_left % 5) != 0;
      endcase
    end
  end

  // ---- watchdog ----------------------------------------------------------------
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- main sequence -------------------------------------------------------------
  typedef struct {
    word_t     w;
    bit        hand;
    skin_res_t want;
  } step_t;

  step_t directed [$];

  task automatic add_row(input word_t w, input bit hand, input skin_res_t want);
    step_t s;
    s.w = w;
    s.hand = hand;
    s.want = want;
    directed.push_back(s);
  endtask

  initial begin
    word_t w;
    int    pick;
    int    sent;
    q16_t  one;
    one = 32'sh0001_0000;
    n_errors = 0; n_writes = 0; n_skins = 0; n_checked = 0; n_sat = 0;
    burst_left = 0;
    for (int i = 0; i < PAL_DEPTH; i++) palette_mirror[i] = '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_WRITE;
    in_ch.pal_addr <= '0;
    in_ch.pal_value <= '0;
    in_ch.joint_ids <= '0;
    in_ch.blend_weights <= '0;
    in_ch.pos_x <= '0; in_ch.pos_y <= '0; in_ch.pos_z <= '0;
    in_ch.nrm_x <= '0; in_ch.nrm_y <= '0; in_ch.nrm_z <= '0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // joint 0 = identity; writes above the palette are dropped
    for (int e = 0; e < WORDS_PER_JOINT; e++)
      add_row(pal_write(e, (e == 0 || e == 5 || e == 10) ? one : 32'sh0), 1'b0, '0);
    add_row(pal_write(PAL_DEPTH, 32'sh7FFF_FFFF), 1'b0, '0);
    add_row(pal_write(1023, 32'sh8000_0000), 1'b0, '0);
    // unit weight on identity passes the vertex through
    add_row(vtx(24'h0, 64'h8000, 32'sh0001_8000, 32'shFFFE_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh0, 32'sh1), 1'b1,
            {32'sh1, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFE_0000, 32'sh0001_8000});
    // zero weights give a zero matrix
    add_row(vtx(24'h0, 64'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1), 1'b1, '0);
    // weights summing to two saturate at both ends
    add_row(vtx(24'h0, 64'h8000_8000, 32'sh7FFF_FFFF, 32'sh8000_0000, one,
                32'shFFFF_0000, 32'sh0, 32'sh7FFF_FFFF), 1'b1,
            {32'sh7FFF_FFFF, 32'sh0, 32'shFFFE_0000, 32'sh0002_0000,
             32'sh8000_0000, 32'sh7FFF_FFFF});
    add_row(vtx(24'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh0003_4000, 32'shFFFF_8001,
                32'sh0, 32'sh0000_B505, 32'shFFFF_4AFB, 32'sh0), 1'b0, '0);
    // translation column is used for the point only
    add_row(pal_write(3, 32'sh7FFF_FFFF), 1'b0, '0);
    add_row(pal_write(7, 32'sh8000_0000), 1'b0, '0);
    add_row(vtx(24'h0, 64'h4000, 32'sh0001_0000, 32'sh0, 32'shFFFF_FFFF,
                32'sh0001_0000, 32'sh0, 32'sh0), 1'b0, '0);
    add_row(vtx(24'h0, 64'h8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0,
                32'sh0, 32'sh0, 32'sh0), 1'b0, '0);
    foreach (directed[i]) send(directed[i].w, directed[i].hand, directed[i].want);
    joint_loaded[0] = 1'b1;
    loaded_joints.push_back(0);

    sent = 0;
    upload_joint(MAX_JOINTS - 1);
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        upload_joint($urandom_range(0, MAX_JOINTS - 1));
        sent += WORDS_PER_JOINT;
      end else if (pick < 13) begin
        w = pal_write(loaded_joints[$urandom_range(0, loaded_joints.size() - 1)] *
                      WORDS_PER_JOINT + $urandom_range(0, WORDS_PER_JOINT - 1), rnd_elem());
        send(w, 1'b0, '0);
        sent++;
      end else if (pick < 16) begin
        send(pal_write($urandom_range(PAL_DEPTH, 1023), $urandom), 1'b0, '0);
        sent++;
      end else begin
        w = vtx('0, rnd_weights(), rnd_coord(), rnd_coord(), rnd_coord(),
                rnd_coord(), rnd_coord(), rnd_coord());
        for (int k = 0; k < NUM_INF; k++)
          w.joint_ids[JID_W*k +: JID_W] =
            JID_W'(loaded_joints[$urandom_range(0, loaded_joints.size() - 1)]);
        send(w, 1'b0, '0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (skinned_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d palette writes and %0d vertices over %0d joints",
             n_writes, n_skins, loaded_joints.size());
    $display("%0d results compared, %0d saturated fields, %0d mismatches",
             n_checked, n_sat, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
